// File: hw/rtl/rcsg_pkg.sv
// rcsg_pkg: shared constants, codes and structs of the raycast column span generator
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package rcsg_pkg;

	// screen and texture geometry
	localparam int SCREEN_ROWS = 480;
	localparam int TEX_WIDTH   = 64;
	localparam int TEX_HEIGHT  = 64;
	localparam int HALF_ROWS   = SCREEN_ROWS / 2;

	// fixed point one in q16.16
	localparam int FRAC_ONE = 65536;

	// dividends of the two setup divisions
	localparam int LH_NUM   = SCREEN_ROWS * FRAC_ONE;
	localparam int STEP_NUM = TEX_HEIGHT * FRAC_ONE;
	localparam int NUM_MAX  = (LH_NUM > STEP_NUM) ? LH_NUM : STEP_NUM;
	localparam int NUM_W    = $clog2(NUM_MAX + 1);
	localparam int DEN_W    = 31;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	// field widths
	localparam int DIST_W    = 31;
	localparam int POS_W     = 24;
	localparam int DIR_W     = 18;
	localparam int CELL_W    = 16;
	localparam int COL_W     = 11;
	localparam int ROW_W     = 10;
	localparam int TEX_W     = 6;
	localparam int COLOR_W   = 24;
	localparam int KIND_W    = 2;
	localparam int FACE_W    = 2;
	localparam int ACC_W     = 32;
	localparam int MUL_W     = 32;
	localparam int U_W       = 11;
	localparam int CFG_IDX_W = 1;

	// texture row mask applied to the integer part of the accumulator
	localparam logic [TEX_W-1:0] TH_MASK = TEX_W'(TEX_HEIGHT - 1);

	// item commands
	localparam logic CMD_SETUP = 1'b0;
	localparam logic CMD_ROW   = 1'b1;

	// pixel kinds
	localparam logic [KIND_W-1:0] KIND_CEIL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd2;

	// wall faces
	localparam logic [FACE_W-1:0] FACE_WEST  = 2'd0;
	localparam logic [FACE_W-1:0] FACE_EAST  = 2'd1;
	localparam logic [FACE_W-1:0] FACE_NORTH = 2'd2;
	localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b1;

	// ray hit fields of a setup item
	typedef struct packed {
		logic [COL_W-1:0]         column;
		logic                     hit_side;
		logic [DIST_W-1:0]        line_dist_x;
		logic [DIST_W-1:0]        line_dist_y;
		logic [DIST_W-1:0]        grid_step_x;
		logic [DIST_W-1:0]        grid_step_y;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic signed [DIR_W-1:0]  ray_dir_x;
		logic signed [DIR_W-1:0]  ray_dir_y;
		logic [CELL_W-1:0]        hit_cell_xy;
	} rcsg_setup_t;

	// finished column parameters
	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [FACE_W-1:0] face;
		logic [TEX_W-1:0]  tex_col;
		logic [ROW_W-1:0]  span_start;
		logic [ROW_W-1:0]  span_end;
		logic [ACC_W-1:0]  tex_accum;
		logic [ACC_W-1:0]  tex_step;
	} rcsg_col_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcsg_if.sv
// rcsg_in_if and rcsg_out_if: valid/ready channels for items and pixels
// depends on rcsg_pkg for field widths
`default_nettype none

interface rcsg_in_if;
	import rcsg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [COL_W-1:0]         column;
	logic                     hit_side;
	logic [DIST_W-1:0]        line_dist_x;
	logic [DIST_W-1:0]        line_dist_y;
	logic [DIST_W-1:0]        grid_step_x;
	logic [DIST_W-1:0]        grid_step_y;
	logic [POS_W-1:0]         pos_x;
	logic [POS_W-1:0]         pos_y;
	logic signed [DIR_W-1:0]  ray_dir_x;
	logic signed [DIR_W-1:0]  ray_dir_y;
	logic [CELL_W-1:0]        hit_cell_xy;

	modport source (
		output valid, command, column, hit_side, line_dist_x, line_dist_y,
		       grid_step_x, grid_step_y, pos_x, pos_y, ray_dir_x, ray_dir_y,
		       hit_cell_xy,
		input  ready
	);

	modport sink (
		input  valid, command, column, hit_side, line_dist_x, line_dist_y,
		       grid_step_x, grid_step_y, pos_x, pos_y, ray_dir_x, ray_dir_y,
		       hit_cell_xy,
		output ready
	);
endinterface

interface rcsg_out_if;
	import rcsg_pkg::*;

	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   out_column;
	logic [ROW_W-1:0]   out_row;
	logic [KIND_W-1:0]  pixel_kind;
	logic [FACE_W-1:0]  wall_face;
	logic [TEX_W-1:0]   tex_u;
	logic [TEX_W-1:0]   tex_v;
	logic [COLOR_W-1:0] flat_color;
	logic               last;

	modport source (
		output valid, out_column, out_row, pixel_kind, wall_face, tex_u, tex_v,
		       flat_color, last,
		input  ready
	);

	modport sink (
		input  valid, out_column, out_row, pixel_kind, wall_face, tex_u, tex_v,
		       flat_color, last,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/rcsg_div.sv
// rcsg_div: bit-serial restoring divider, one quotient bit per cycle
// depends on rcsg_pkg for dividend and divisor widths
`default_nettype none

module rcsg_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rcsg_pkg::NUM_W-1:0]  num,
	input  wire logic [rcsg_pkg::DEN_W-1:0]  den,
	output logic                             done,
	output logic [rcsg_pkg::NUM_W-1:0]       quo
);
	import rcsg_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

`default_nettype wire

// File: hw/rtl/rcsg_setup.sv
// rcsg_setup: column setup sequencer around one shared multiplier and the divider
// depends on rcsg_pkg and rcsg_div
`default_nettype none

module rcsg_setup (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire rcsg_pkg::rcsg_setup_t setup,
	output logic                       busy,
	output logic                       done,
	output rcsg_pkg::rcsg_col_t        col
);
	import rcsg_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_MUL_DIR  = 10'b00_0000_0010,
		S_FRAC     = 10'b00_0000_0100,
		S_MUL_TW   = 10'b00_0000_1000,
		S_TEXCOL   = 10'b00_0001_0000,
		S_DIV_LH   = 10'b00_0010_0000,
		S_SPAN     = 10'b00_0100_0000,
		S_DIV_STEP = 10'b00_1000_0000,
		S_MUL_ACC  = 10'b01_0000_0000,
		S_COMMIT   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [DIST_W-1:0]       perp_q;
	logic [15:0]             base_q;
	logic signed [DIR_W-1:0] dir_q;
	logic                    mirror_q;
	logic [FACE_W-1:0]       face_q;
	logic [COL_W-1:0]        column_q;
	logic [MUL_W-1:0]        frac_q;
	logic [TEX_W-1:0]        tex_col_q;
	logic [NUM_W-1:0]        lh_q;
	logic [NUM_W-1:0]        accb_q;
	logic [ROW_W-1:0]        span_start_q;
	logic [ROW_W-1:0]        span_end_q;
	logic [ACC_W-1:0]        step_q;
	logic [2*MUL_W-1:0]      prod_q;

	logic [DIST_W-1:0]       sd;
	logic [DIST_W-1:0]       dd;
	logic [DIST_W-1:0]       perp;
	logic [FACE_W-1:0]       face;
	logic                    mirror;
	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [U_W-1:0]          u;
	logic [U_W-1:0]          u_col;
	logic [NUM_W-1:0]        half;
	logic                    half_ge;
	logic [NUM_W:0]          end_sum;
	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_done;
	logic [NUM_W-1:0]        div_quo;

	// perpendicular distance, face and mirror from the ray hit
	always_comb begin
		sd = setup.hit_side ? setup.line_dist_y : setup.line_dist_x;
		dd = setup.hit_side ? setup.grid_step_y : setup.grid_step_x;
		perp = (sd >= dd) ? (sd - dd) : '0;
		if (setup.hit_side) begin
			mirror = setup.ray_dir_y[DIR_W-1];
			face = ({setup.hit_cell_xy[7:0], 16'h0000} < setup.pos_y) ? FACE_NORTH
			                                                         : FACE_SOUTH;
		end else begin
			mirror = !setup.ray_dir_x[DIR_W-1] && (setup.ray_dir_x != '0);
			face = ({setup.hit_cell_xy[15:8], 16'h0000} < setup.pos_x) ? FACE_WEST
			                                                          : FACE_EAST;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = {1'b0, perp_q};
		mul_b = {{(MUL_W-DIR_W){dir_q[DIR_W-1]}}, dir_q};
		case (state_q)
			S_MUL_TW: begin
				mul_a = frac_q;
				mul_b = MUL_W'(TEX_WIDTH);
			end
			S_MUL_ACC: begin
				mul_a = MUL_W'(accb_q);
				mul_b = step_q;
			end
			default: ;
		endcase
	end

	// texture column from the upper product bits
	always_comb begin
		u     = prod_q[MUL_W +: U_W];
		u_col = mirror_q ? u : (U_W'(TEX_WIDTH - 1) - u);
	end

	// span limits from the line height
	always_comb begin
		half    = lh_q >> 1;
		half_ge = half >= NUM_W'(HALF_ROWS);
		end_sum = {1'b0, half} + (NUM_W+1)'(HALF_ROWS);
	end

	// divider requests: line height, then texture step
	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(LH_NUM);
		div_den   = perp_q;
		if (state_q == S_TEXCOL) begin
			div_start = perp_q != '0;
		end else if (state_q == S_SPAN) begin
			div_start = lh_q != '0;
			div_num   = NUM_W'(STEP_NUM);
			div_den   = DEN_W'(lh_q);
		end
	end

	rcsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:     if (start) state_q <= S_MUL_DIR;
				S_MUL_DIR:  state_q <= S_FRAC;
				S_FRAC:     state_q <= S_MUL_TW;
				S_MUL_TW:   state_q <= S_TEXCOL;
				S_TEXCOL:   state_q <= S_DIV_LH;
				S_DIV_LH:   if (perp_q == '0 || div_done) state_q <= S_SPAN;
				S_SPAN:     state_q <= S_DIV_STEP;
				S_DIV_STEP: if (lh_q == '0 || div_done) state_q <= S_MUL_ACC;
				S_MUL_ACC:  state_q <= S_COMMIT;
				S_COMMIT:   state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					perp_q   <= perp;
					base_q   <= setup.hit_side ? setup.pos_x[15:0] : setup.pos_y[15:0];
					dir_q    <= setup.hit_side ? setup.ray_dir_x : setup.ray_dir_y;
					mirror_q <= mirror;
					face_q   <= face;
					column_q <= setup.column;
				end
			end
			S_FRAC:   frac_q <= {base_q, 16'h0000} + prod_q[MUL_W-1:0];
			S_TEXCOL: tex_col_q <= u_col[TEX_W-1:0];
			S_DIV_LH: lh_q <= (perp_q == '0) ? NUM_W'(LH_NUM) : div_quo;
			S_SPAN: begin
				span_start_q <= half_ge ? '0 : ROW_W'(NUM_W'(HALF_ROWS) - half);
				span_end_q   <= (end_sum >= (NUM_W+1)'(SCREEN_ROWS))
				                ? ROW_W'(SCREEN_ROWS - 1) : end_sum[ROW_W-1:0];
				accb_q       <= half_ge ? (half - NUM_W'(HALF_ROWS)) : '0;
			end
			S_DIV_STEP: step_q <= (lh_q == '0) ? '1 : ACC_W'(div_quo);
			default: ;
		endcase
	end

	// column result, taken by the row stage on done
	always_comb begin
		col.column     = column_q;
		col.face       = face_q;
		col.tex_col    = tex_col_q;
		col.span_start = span_start_q;
		col.span_end   = span_end_q;
		col.tex_accum  = prod_q[ACC_W-1:0];
		col.tex_step   = step_q;
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_COMMIT;

endmodule

`default_nettype wire

// File: hw/rtl/raycast_column_span_generator_core.sv
// raycast_column_span_generator_core: top level, row pixel stage and configuration
// depends on rcsg_pkg, rcsg_if and rcsg_setup
`default_nettype none

// A setup item (command 0) loads one ray's grid hit and produces no pixel; the
// block then computes the wall distance, texture column, line height, clamped
// span, texture step and face with one shared 32x32 multiplier and a bit-serial
// divider, and is not ready while that setup sequence runs; a zero wall
// distance or a zero line height skips one division. Row items (command 1) then
// emit one pixel each, top to bottom, one per cycle while the output is not
// stalled, with last on the bottom screen row; a row item with no loaded column
// is dropped. Pixels leave through one output register. Colors are written on
// the cfg port.
module raycast_column_span_generator_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [rcsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcsg_pkg::COLOR_W-1:0]   cfg_data,
	rcsg_in_if.sink                             item,
	rcsg_out_if.source                          pixel
);
	import rcsg_pkg::*;

	logic [COLOR_W-1:0] ceiling_q;
	logic [COLOR_W-1:0] floor_q;

	logic               loaded_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   column_q;
	logic [FACE_W-1:0]  face_q;
	logic [TEX_W-1:0]   tex_col_q;
	logic [ROW_W-1:0]   span_start_q;
	logic [ROW_W-1:0]   span_end_q;
	logic [ACC_W-1:0]   accum_q;
	logic [ACC_W-1:0]   step_q;

	logic               out_valid_q;
	logic [COL_W-1:0]   out_column_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [KIND_W-1:0]  kind_q;
	logic [FACE_W-1:0]  out_face_q;
	logic [TEX_W-1:0]   tex_u_q;
	logic [TEX_W-1:0]   tex_v_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;

	rcsg_setup_t        setup;
	rcsg_col_t          col;
	logic               setup_busy;
	logic               setup_done;
	logic               fire;
	logic               setup_start;
	logic               row_fire;
	logic               out_free;
	logic [KIND_W-1:0]  kind;
	logic               last;

	// setup fields of the incoming item
	always_comb begin
		setup.column       = item.column;
		setup.hit_side     = item.hit_side;
		setup.line_dist_x  = item.line_dist_x;
		setup.line_dist_y  = item.line_dist_y;
		setup.grid_step_x  = item.grid_step_x;
		setup.grid_step_y  = item.grid_step_y;
		setup.pos_x        = item.pos_x;
		setup.pos_y        = item.pos_y;
		setup.ray_dir_x    = item.ray_dir_x;
		setup.ray_dir_y    = item.ray_dir_y;
		setup.hit_cell_xy  = item.hit_cell_xy;
	end

	// input transfer and command split
	always_comb begin
		out_free    = !out_valid_q || pixel.ready;
		item.ready  = !setup_busy && out_free;
		fire        = item.valid && item.ready;
		setup_start = fire && (item.command == CMD_SETUP);
		row_fire    = fire && (item.command == CMD_ROW) && loaded_q;
	end

	rcsg_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (setup_start),
		.setup  (setup),
		.busy   (setup_busy),
		.done   (setup_done),
		.col    (col)
	);

	// pixel classification of the current row
	always_comb begin
		if (row_q < span_start_q) begin
			kind = KIND_CEIL;
		end else if (row_q <= span_end_q) begin
			kind = KIND_WALL;
		end else begin
			kind = KIND_FLOOR;
		end
		last = ({1'b0, row_q} + (ROW_W+1)'(1)) >= (ROW_W+1)'(SCREEN_ROWS);
	end

	// color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= '0;
			floor_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CEILING: ceiling_q <= cfg_data;
				CFG_FLOOR:   floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// column state: loaded by setup, advanced by each row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= 1'b0;
			row_q        <= '0;
			column_q     <= '0;
			face_q       <= FACE_WEST;
			tex_col_q    <= '0;
			span_start_q <= '0;
			span_end_q   <= '0;
			accum_q      <= '0;
			step_q       <= '0;
		end else if (setup_done) begin
			loaded_q     <= 1'b1;
			row_q        <= '0;
			column_q     <= col.column;
			face_q       <= col.face;
			tex_col_q    <= col.tex_col;
			span_start_q <= col.span_start;
			span_end_q   <= col.span_end;
			accum_q      <= col.tex_accum;
			step_q       <= col.tex_step;
		end else if (row_fire) begin
			row_q <= row_q + ROW_W'(1);
			if (kind == KIND_WALL) begin
				accum_q <= accum_q + step_q;
			end
			if (last) begin
				loaded_q <= 1'b0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (row_fire) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (row_fire) begin
			out_column_q <= column_q;
			out_row_q    <= row_q;
			kind_q       <= kind;
			out_face_q   <= face_q;
			last_q       <= last;
			case (kind)
				KIND_CEIL: begin
					tex_u_q <= '0;
					tex_v_q <= '0;
					color_q <= ceiling_q;
				end
				KIND_WALL: begin
					tex_u_q <= tex_col_q;
					tex_v_q <= accum_q[16 +: TEX_W] & TH_MASK;
					color_q <= '0;
				end
				default: begin
					tex_u_q <= '0;
					tex_v_q <= '0;
					color_q <= floor_q;
				end
			endcase
		end
	end

	// pixel transfer
	always_comb begin
		pixel.valid      = out_valid_q;
		pixel.out_column = out_column_q;
		pixel.out_row    = out_row_q;
		pixel.pixel_kind = kind_q;
		pixel.wall_face  = out_face_q;
		pixel.tex_u      = tex_u_q;
		pixel.tex_v      = tex_v_q;
		pixel.flat_color = color_q;
		pixel.last       = last_q;
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for raycast_column_span_generator_core
// depends on rcsg_pkg and the rcsg_in_if / rcsg_out_if channels of the rtl
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcsg_pkg::*;

	localparam int RUN_LIMIT  = 400000;
	localparam int SETUP_WAIT = 2 * NUM_W + 24;
	localparam int MAX_PRINTS = 40;
	localparam int PHASE_ITEMS = 135;

	// one expected or observed pixel
	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		logic [KIND_W-1:0]  kind;
		logic [FACE_W-1:0]  face;
		logic [TEX_W-1:0]   u;
		logic [TEX_W-1:0]   v;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	rcsg_in_if  item_ch ();
	rcsg_out_if pix_ch ();

	raycast_column_span_generator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.pixel     (pix_ch)
	);

	// color registers as the block should hold them
	logic [COLOR_W-1:0] ceil_rgb;
	logic [COLOR_W-1:0] floor_rgb;

	// loaded column as the block should hold it
	logic [COL_W-1:0]  ld_col;
	logic [FACE_W-1:0] ld_face;
	logic [TEX_W-1:0]  ld_texu;
	logic [ROW_W-1:0]  ld_top;
	logic [ROW_W-1:0]  ld_bottom;
	logic [ROW_W-1:0]  ld_row;
	logic [ACC_W-1:0]  ld_vacc;
	logic [ACC_W-1:0]  ld_vstep;
	logic              ld_active;

	pixel_t pending_pixels[$];
	int     error_count;
	int     items_taken;
	int     cycle_count;
	int     stall_left;
	bit     tx_calm;
	bit     rx_calm;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// wall distance, texture column, span, texture row walk and face of a new column
	function automatic void setup_column(input rcsg_setup_t s);
		logic [63:0] perp, base, dir, frac, u, lh, half, hs, bottom, stp;
		logic [7:0]  mx, my;
		logic        mirror;
		mx = s.hit_cell_xy[15:8];
		my = s.hit_cell_xy[7:0];
		hs = 64'(HALF_ROWS);
		if (s.hit_side == 1'b0) begin
			perp = (s.line_dist_x >= s.grid_step_x) ?
				64'(s.line_dist_x - s.grid_step_x) : 64'd0;
			base = 64'(s.pos_y) << 16;
			dir = {{(64-DIR_W){s.ray_dir_y[DIR_W-1]}}, s.ray_dir_y};
			mirror = !s.ray_dir_x[DIR_W-1] && (s.ray_dir_x != '0);
			ld_face = ({mx, 16'h0} < s.pos_x) ? FACE_WEST : FACE_EAST;
		end else begin
			perp = (s.line_dist_y >= s.grid_step_y) ?
				64'(s.line_dist_y - s.grid_step_y) : 64'd0;
			base = 64'(s.pos_x) << 16;
			dir = {{(64-DIR_W){s.ray_dir_x[DIR_W-1]}}, s.ray_dir_x};
			mirror = s.ray_dir_y[DIR_W-1];
			ld_face = ({my, 16'h0} < s.pos_y) ? FACE_NORTH : FACE_SOUTH;
		end
		// fraction of the hit coordinate scaled to the texture width
		frac = (base + perp * dir) & 64'hFFFF_FFFF;
		u = (frac * 64'(TEX_WIDTH)) >> 32;
		if (!mirror)
			u = 64'(TEX_WIDTH) - 64'd1 - u;
		ld_texu = u[TEX_W-1:0];
		// line height and clamped span, zero distance saturates
		lh = (perp != 64'd0) ? (64'(SCREEN_ROWS) << 16) / perp : 64'(SCREEN_ROWS) << 16;
		half = lh >> 1;
		ld_top = (half >= hs) ? '0 : ROW_W'(hs - half);
		bottom = hs + half;
		if (bottom >= 64'(SCREEN_ROWS))
			bottom = 64'(SCREEN_ROWS - 1);
		ld_bottom = ROW_W'(bottom);
		// texture row step, saturated for a zero height
		stp = (lh != 64'd0) ? (64'(TEX_HEIGHT) << 16) / lh : 64'hFFFF_FFFF;
		if (stp > 64'hFFFF_FFFF)
			stp = 64'hFFFF_FFFF;
		ld_vstep = stp[ACC_W-1:0];
		ld_vacc = ACC_W'((64'(ld_top) + half - hs) * stp);
		ld_col = s.column;
		ld_row = '0;
		ld_active = 1'b1;
	endfunction

	// pixel of the next row, none when no column is loaded
	function automatic bit next_pixel(output pixel_t px);
		logic [ROW_W-1:0] r;
		px = '0;
		if (!ld_active)
			return 1'b0;
		r = ld_row;
		px.column = ld_col;
		px.row = r;
		px.face = ld_face;
		if (r < ld_top) begin
			px.kind = KIND_CEIL;
			px.color = ceil_rgb;
		end else if (r <= ld_bottom) begin
			px.kind = KIND_WALL;
			px.u = ld_texu;
			px.v = TEX_W'((ld_vacc >> 16) & ACC_W'(TEX_HEIGHT - 1));
			ld_vacc = ld_vacc + ld_vstep;
		end else begin
			px.kind = KIND_FLOOR;
			px.color = floor_rgb;
		end
		px.last = (32'(r) + 1 >= SCREEN_ROWS);
		ld_row = r + 1'b1;
		if (px.last)
			ld_active = 1'b0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (error_count < MAX_PRINTS)
				$display("%0t pixel %s mismatch: expected %0h actual %0h",
					$time, name, want, got);
			error_count++;
		end
	endfunction

	// result side: compare each transfer with the oldest expectation, then draw a stall
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		pixel_t got;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			got.column = pix_ch.out_column;
			got.row = pix_ch.out_row;
			got.kind = pix_ch.pixel_kind;
			got.face = pix_ch.wall_face;
			got.u = pix_ch.tex_u;
			got.v = pix_ch.tex_v;
			got.color = pix_ch.flat_color;
			got.last = pix_ch.last;
			if (pending_pixels.size() == 0) begin
				if (error_count < MAX_PRINTS)
					$display("%0t unexpected pixel: expected none actual %0h", $time, got);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_column", want.column, got.column);
				check_field("out_row", want.row, got.row);
				check_field("pixel_kind", want.kind, got.kind);
				check_field("wall_face", want.face, got.face);
				check_field("tex_u", want.u, got.u);
				check_field("tex_v", want.v, got.v);
				check_field("flat_color", want.color, got.color);
				check_field("last", want.last, got.last);
			end
			stall_left = rx_calm ? 0 : $urandom_range(0, 15);
		end
	end

	// ready follows the drawn stall
	always @(negedge clk) begin
		pix_ch.ready = (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	// one item transfer, starting and ending at a falling edge
	task automatic send_item(input logic cmd, input rcsg_setup_t s);
		int     gap;
		pixel_t px;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.command = cmd;
		item_ch.column = s.column;
		item_ch.hit_side = s.hit_side;
		item_ch.line_dist_x = s.line_dist_x;
		item_ch.line_dist_y = s.line_dist_y;
		item_ch.grid_step_x = s.grid_step_x;
		item_ch.grid_step_y = s.grid_step_y;
		item_ch.pos_x = s.pos_x;
		item_ch.pos_y = s.pos_y;
		item_ch.ray_dir_x = s.ray_dir_x;
		item_ch.ray_dir_y = s.ray_dir_y;
		item_ch.hit_cell_xy = s.hit_cell_xy;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		// ignored rows do not count as stimulus
		if (cmd == CMD_SETUP) begin
			setup_column(s);
			items_taken++;
		end else if (next_pixel(px)) begin
			pending_pixels.push_back(px);
			items_taken++;
		end
		@(negedge clk);
	endtask

	function automatic rcsg_setup_t noise_setup();
		rcsg_setup_t s;
		s.column = COL_W'($urandom);
		s.hit_side = 1'($urandom_range(0, 1));
		s.line_dist_x = DIST_W'($urandom);
		s.line_dist_y = DIST_W'($urandom);
		s.grid_step_x = DIST_W'($urandom);
		s.grid_step_y = DIST_W'($urandom);
		s.pos_x = POS_W'($urandom);
		s.pos_y = POS_W'($urandom);
		s.ray_dir_x = DIR_W'($urandom);
		s.ray_dir_y = DIR_W'($urandom);
		s.hit_cell_xy = CELL_W'($urandom);
		return s;
	endfunction

	task automatic send_column(input rcsg_setup_t s, input int rows);
		send_item(CMD_SETUP, s);
		repeat (rows) send_item(CMD_ROW, noise_setup());
	endtask

	// wait for every pixel, then for a setup still in the divider
	task automatic settle();
		item_ch.valid = 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETUP_WAIT) @(negedge clk);
	endtask

	task automatic write_colors(input logic [COLOR_W-1:0] ceil_c,
			input logic [COLOR_W-1:0] floor_c);
		cfg_wr_en = 1'b1;
		cfg_index = CFG_CEILING;
		cfg_data = ceil_c;
		@(negedge clk);
		cfg_index = CFG_FLOOR;
		cfg_data = floor_c;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ceil_rgb = ceil_c;
		floor_rgb = floor_c;
	endtask

	// consistent distances over a spread of wall heights, cell often beside the player
	function automatic rcsg_setup_t wall_setup();
		rcsg_setup_t s;
		logic [31:0] perp, dd;
		s = noise_setup();
		case ($urandom_range(0, 3))
			0: perp = $urandom_range(0, 32'h0002_0000);
			1: perp = $urandom_range(32'h0001_0000, 32'h0040_0000);
			2: perp = $urandom_range(0, 32'h0200_0000);
			default: perp = $urandom_range(32'h01E0_0000, 32'h7FFF_FFFF);
		endcase
		dd = $urandom_range(0, 32'h7FFF_FFFF - perp);
		if (s.hit_side == 1'b0) begin
			s.grid_step_x = DIST_W'(dd);
			s.line_dist_x = DIST_W'(dd + perp);
		end else begin
			s.grid_step_y = DIST_W'(dd);
			s.line_dist_y = DIST_W'(dd + perp);
		end
		if ($urandom_range(0, 1) == 0)
			s.hit_cell_xy = {s.pos_x[23:16] + 8'($urandom_range(0, 1)),
				s.pos_y[23:16] + 8'($urandom_range(0, 1))};
		return s;
	endfunction

	// rows before any column is loaded produce nothing
	task automatic test_rows_without_column();
		send_item(CMD_ROW, noise_setup());
		send_item(CMD_ROW, noise_setup());
		settle();
	endtask

	task automatic test_color_registers();
		write_colors(24'hFF_FFFF, 24'h00_0000);
	endtask

	// distance extremes, mirroring on both sides and all four faces
	task automatic test_special_columns();
		rcsg_setup_t s;
		// side distance below delta: zero distance, full height wall
		s = '0;
		s.column = 11'h7FF;
		s.grid_step_x = 31'h7FFF_FFFF;
		s.line_dist_y = 31'h7FFF_FFFF;
		s.grid_step_y = 31'h7FFF_FFFF;
		s.pos_x = 24'hFF_FFFF;
		s.pos_y = 24'hFF_FFFF;
		s.ray_dir_x = 18'h1_FFFF;
		s.ray_dir_y = 18'h2_0000;
		s.hit_cell_xy = 16'hFFFF;
		send_column(s, 3);
		// far wall: zero height, single middle row, mirrored y side
		s = '0;
		s.hit_side = 1'b1;
		s.line_dist_y = 31'h7FFF_FFFF;
		s.ray_dir_x = 18'h1_FFFF;
		s.ray_dir_y = 18'h2_0000;
		send_column(s, 2);
		// span starting a few rows down: ceiling then wall
		s = '0;
		s.column = 11'd1000;
		s.grid_step_x = 31'h0001_0000;
		s.line_dist_x = 31'h0001_0000 + 31'd66930;
		s.pos_x = 24'h05_8000;
		s.pos_y = 24'h03_4000;
		s.ray_dir_x = 18'h3_0000;
		s.ray_dir_y = 18'h0_8000;
		s.hit_cell_xy = 16'h0A03;
		send_column(s, 8);
		// unit distance: span covers the screen, north face
		s = '0;
		s.column = 11'd321;
		s.hit_side = 1'b1;
		s.grid_step_y = 31'h0001_0000;
		s.line_dist_y = 31'h0002_0000;
		s.pos_x = 24'h02_C000;
		s.pos_y = 24'h01_0000;
		s.ray_dir_x = 18'h0_4000;
		s.ray_dir_y = 18'h1_0000;
		s.hit_cell_xy = 16'h0200;
		send_column(s, 3);
		settle();
	endtask

	// one column down to the last row, then rows past it that are ignored
	task automatic test_full_column();
		write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		send_column(wall_setup(), SCREEN_ROWS + 3);
		settle();
	endtask

	// random columns over several color settings, cut short of the last row
	task automatic test_random_columns();
		rcsg_setup_t s;
		int start, rows, room;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
				1: write_colors(24'h00_0000, 24'hFF_FFFF);
				2: write_colors(24'hFF_FFFF, 24'h00_0000);
				default: write_colors(COLOR_W'($urandom), COLOR_W'($urandom));
			endcase
			start = items_taken;
			while (items_taken - start < PHASE_ITEMS) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
				s = ($urandom_range(0, 4) == 0) ? noise_setup() : wall_setup();
				if ($urandom_range(0, 3) == 0)
					rows = $urandom_range(49, PHASE_ITEMS - 1);
				else
					rows = $urandom_range(1, 48);
				// setup plus rows stay within the phase budget
				room = PHASE_ITEMS - 1 - (items_taken - start);
				if (rows > room)
					rows = room;
				send_column(s, rows);
			end
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_CEILING;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_SETUP;
		item_ch.column = '0;
		item_ch.hit_side = 1'b0;
		item_ch.line_dist_x = '0;
		item_ch.line_dist_y = '0;
		item_ch.grid_step_x = '0;
		item_ch.grid_step_y = '0;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.ray_dir_x = '0;
		item_ch.ray_dir_y = '0;
		item_ch.hit_cell_xy = '0;
		pix_ch.ready = 1'b0;
		stall_left = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		error_count = 0;
		items_taken = 0;
		cycle_count = 0;
		ceil_rgb = '0;
		floor_rgb = '0;
		ld_col = '0;
		ld_face = FACE_WEST;
		ld_texu = '0;
		ld_top = '0;
		ld_bottom = '0;
		ld_row = '0;
		ld_vacc = '0;
		ld_vstep = '0;
		ld_active = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_rows_without_column();
		test_color_registers();
		test_special_columns();
		test_full_column();
		test_random_columns();
		settle();

		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
